// ----- hdl/evp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evp_pkg
// Shared constants, payload types and helpers for the pose to view matrix
// pipeline.
// ----------------------------------------------------------------------------
package evp_pkg;

   localparam int ANGLE_BITS     = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int POS_BITS       = 32;
   localparam int COEF_W         = COEF_FRAC_BITS + 2;

   localparam int CORDIC_FRAC    = COEF_FRAC_BITS + 24;
   localparam int CORDIC_W       = CORDIC_FRAC + 3;
   localparam int CORDIC_STAGES  = CORDIC_FRAC;

   localparam int SINCOS_LATENCY = CORDIC_STAGES + 2;
   localparam int MATRIX_LATENCY = 3;
   localparam int TRANS_LATENCY  = 4;

   localparam real PI_REAL          = 3.14159265358979323846;
   localparam real QUARTERS_PER_RAD = 2.0 / PI_REAL;

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] rot_x;
      logic signed [ANGLE_BITS-1:0] rot_y;
      logic signed [ANGLE_BITS-1:0] rot_z;
      logic signed [POS_BITS-1:0]   pos_x;
      logic signed [POS_BITS-1:0]   pos_y;
      logic signed [POS_BITS-1:0]   pos_z;
   } evp_req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] col0_r0;
      logic signed [COEF_W-1:0] col0_r1;
      logic signed [COEF_W-1:0] col0_r2;
      logic signed [COEF_W-1:0] col1_r0;
      logic signed [COEF_W-1:0] col1_r1;
      logic signed [COEF_W-1:0] col1_r2;
      logic signed [COEF_W-1:0] col2_r0;
      logic signed [COEF_W-1:0] col2_r1;
      logic signed [COEF_W-1:0] col2_r2;
   } evp_mat_type;

   typedef struct packed {
      logic signed [COEF_W-1:0]   col0_r0;
      logic signed [COEF_W-1:0]   col0_r1;
      logic signed [COEF_W-1:0]   col0_r2;
      logic signed [COEF_W-1:0]   col1_r0;
      logic signed [COEF_W-1:0]   col1_r1;
      logic signed [COEF_W-1:0]   col1_r2;
      logic signed [COEF_W-1:0]   col2_r0;
      logic signed [COEF_W-1:0]   col2_r1;
      logic signed [COEF_W-1:0]   col2_r2;
      logic signed [POS_BITS-1:0] trans_x;
      logic signed [POS_BITS-1:0] trans_y;
      logic signed [POS_BITS-1:0] trans_z;
   } evp_rsp_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] sn;
      logic signed [COEF_W-1:0] cs;
   } evp_sc_type;

   function automatic logic [63:0] real_to_fix(input real v);
      real         rem;
      logic [63:0] f;
      rem = v;
      f   = '0;
      for (int b = 62; b >= 0; b--) begin
         if (rem >= 2.0 ** b) begin
            f[b] = 1'b1;
            rem  = rem - 2.0 ** b;
         end
      end
      return f;
   endfunction

   function automatic logic [CORDIC_W-1:0] atan_quarter(input int i);
      real         v;
      logic [63:0] f;
      v = $atan(2.0 ** (-i)) * QUARTERS_PER_RAD * (2.0 ** CORDIC_FRAC);
      f = real_to_fix(v);
      return f[CORDIC_W-1:0];
   endfunction

   function automatic logic [CORDIC_W-1:0] cordic_gain();
      real         k;
      logic [63:0] f;
      k = 1.0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         k = k * $pow(1.0 + 2.0 ** (-2 * i), -0.5);
      end
      f = real_to_fix(k * (2.0 ** CORDIC_FRAC));
      return f[CORDIC_W-1:0];
   endfunction

   function automatic logic signed [COEF_W-1:0] fmul(input logic signed [COEF_W-1:0] a,
                                                     input logic signed [COEF_W-1:0] b);
      logic signed [2*COEF_W-1:0] p;
      p = a * b;
      return COEF_W'(p >>> COEF_FRAC_BITS);
   endfunction

   function automatic logic signed [COEF_W-1:0] fnmul(input logic signed [COEF_W-1:0] a,
                                                      input logic signed [COEF_W-1:0] b);
      logic signed [2*COEF_W-1:0] p;
      p = a * b;
      p = -p;
      return COEF_W'(p >>> COEF_FRAC_BITS);
   endfunction

endpackage

// ----- hdl/evp_sincos.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evp_sincos
// Pipelined sine and cosine of one binary angle: octant fold, one CORDIC
// rotation per stage, rounding and quadrant unfold.
// ----------------------------------------------------------------------------
module evp_sincos (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [evp_pkg::ANGLE_BITS-1:0]   angle,
   output logic                             out_valid,
   output evp_pkg::evp_sc_type              out_sc
);

   localparam int N    = evp_pkg::CORDIC_STAGES;
   localparam int CW   = evp_pkg::CORDIC_W;
   localparam int RW   = evp_pkg::ANGLE_BITS - 2;
   localparam int DROP = evp_pkg::CORDIC_FRAC - evp_pkg::COEF_FRAC_BITS;
   localparam int KW   = evp_pkg::COEF_W;

   localparam logic [RW-1:0] HALF_QUARTER = RW'(1) << (RW - 1);
   localparam logic [RW:0]   QUARTER      = (RW + 1)'(1) << RW;
   localparam logic signed [CW-1:0] GAIN  = evp_pkg::cordic_gain();
   localparam logic signed [CW-1:0] RND   = CW'(1) << (DROP - 1);

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   logic signed [CW-1:0] x_ff [0:N];
   logic signed [CW-1:0] y_ff [0:N];
   logic signed [CW-1:0] z_ff [0:N];
   logic [1:0]           q_ff [0:N];
   logic                 swap_ff [0:N];
   logic                 valid_ff [0:N];

   logic [RW-1:0]        r;
   logic [RW:0]          t_full;
   logic                 swap_in;
   logic signed [CW-1:0] z_in;

   assign r       = angle[RW-1:0];
   assign swap_in = r > HALF_QUARTER;
   assign t_full  = swap_in ? (QUARTER - {1'b0, r}) : {1'b0, r};
   assign z_in    = signed'(CW'(t_full) << (evp_pkg::CORDIC_FRAC - RW));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      x_ff[0]    <= GAIN;
      y_ff[0]    <= '0;
      z_ff[0]    <= z_in;
      q_ff[0]    <= angle[RW+1:RW];
      swap_ff[0] <= swap_in;
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      localparam logic signed [CW-1:0] ATAN = evp_pkg::atan_quarter(i);
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      logic                 dir;
      logic signed [CW-1:0] x_in;
      logic signed [CW-1:0] y_in;
      logic signed [CW-1:0] zn_in;

      assign xs    = x_ff[i] >>> i;
      assign ys    = y_ff[i] >>> i;
      assign dir   = z_ff[i][CW-1];
      assign x_in  = dir ? (x_ff[i] + ys) : (x_ff[i] - ys);
      assign y_in  = dir ? (y_ff[i] - xs) : (y_ff[i] + xs);
      assign zn_in = dir ? (z_ff[i] + ATAN) : (z_ff[i] - ATAN);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
         x_ff[i+1]    <= x_in;
         y_ff[i+1]    <= y_in;
         z_ff[i+1]    <= zn_in;
         q_ff[i+1]    <= q_ff[i];
         swap_ff[i+1] <= swap_ff[i];
      end
   end

   logic signed [CW-1:0] ysum;
   logic signed [CW-1:0] xsum;
   logic signed [KW-1:0] sv;
   logic signed [KW-1:0] cv;
   logic signed [KW-1:0] s0;
   logic signed [KW-1:0] c0;
   evp_pkg::evp_sc_type  sc_in;
   evp_pkg::evp_sc_type  sc_ff;
   logic                 out_valid_ff;

   assign ysum = y_ff[N] + RND;
   assign xsum = x_ff[N] + RND;
   assign sv   = y_ff[N][CW-1] ? '0 : KW'(ysum >>> DROP);
   assign cv   = x_ff[N][CW-1] ? '0 : KW'(xsum >>> DROP);
   assign s0   = swap_ff[N] ? cv : sv;
   assign c0   = swap_ff[N] ? sv : cv;

   always_comb begin
      case (q_ff[N])
         QUAD_0: begin
            sc_in.sn = s0;
            sc_in.cs = c0;
         end
         QUAD_1: begin
            sc_in.sn = c0;
            sc_in.cs = -s0;
         end
         QUAD_2: begin
            sc_in.sn = -s0;
            sc_in.cs = -c0;
         end
         default: begin
            sc_in.sn = -c0;
            sc_in.cs = s0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[N];
      end
      sc_ff <= sc_in;
   end

   assign out_valid = out_valid_ff;
   assign out_sc    = sc_ff;

endmodule

// ----- hdl/evp_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evp_matrix
// Three stage product tree forming the nine rotation entries from the sines
// and cosines of the three angles.
// ----------------------------------------------------------------------------
module evp_matrix (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  evp_pkg::evp_sc_type  sc_x,
   input  evp_pkg::evp_sc_type  sc_y,
   input  evp_pkg::evp_sc_type  sc_z,
   output logic                 out_valid,
   output evp_pkg::evp_mat_type out_mat
);

   localparam int KW = evp_pkg::COEF_W;

   // stage 1
   logic signed [KW-1:0] czcy_ff, szsx_ff, czsx_ff, szcy_ff, ncxsy_ff;
   logic signed [KW-1:0] nszcx_ff, czcx_ff, czsy_ff, szsy_ff, cxcy_ff;
   logic signed [KW-1:0] sx1_ff, sy1_ff, cy1_ff;
   logic                 v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      czcy_ff  <= evp_pkg::fmul(sc_z.cs, sc_y.cs);
      szsx_ff  <= evp_pkg::fmul(sc_z.sn, sc_x.sn);
      czsx_ff  <= evp_pkg::fmul(sc_z.cs, sc_x.sn);
      szcy_ff  <= evp_pkg::fmul(sc_z.sn, sc_y.cs);
      ncxsy_ff <= evp_pkg::fnmul(sc_x.cs, sc_y.sn);
      nszcx_ff <= evp_pkg::fnmul(sc_z.sn, sc_x.cs);
      czcx_ff  <= evp_pkg::fmul(sc_z.cs, sc_x.cs);
      czsy_ff  <= evp_pkg::fmul(sc_z.cs, sc_y.sn);
      szsy_ff  <= evp_pkg::fmul(sc_z.sn, sc_y.sn);
      cxcy_ff  <= evp_pkg::fmul(sc_x.cs, sc_y.cs);
      sx1_ff   <= sc_x.sn;
      sy1_ff   <= sc_y.sn;
      cy1_ff   <= sc_y.cs;
   end

   // stage 2
   logic signed [KW-1:0] szsxsy_ff, czsxsy_ff, szsxcy_ff, czsxcy_ff;
   logic signed [KW-1:0] czcy2_ff, szcy2_ff, ncxsy2_ff, nszcx2_ff, czcx2_ff;
   logic signed [KW-1:0] czsy2_ff, szsy2_ff, cxcy2_ff, sx2_ff;
   logic                 v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      szsxsy_ff <= evp_pkg::fmul(szsx_ff, sy1_ff);
      czsxsy_ff <= evp_pkg::fmul(czsx_ff, sy1_ff);
      szsxcy_ff <= evp_pkg::fmul(szsx_ff, cy1_ff);
      czsxcy_ff <= evp_pkg::fmul(czsx_ff, cy1_ff);
      czcy2_ff  <= czcy_ff;
      szcy2_ff  <= szcy_ff;
      ncxsy2_ff <= ncxsy_ff;
      nszcx2_ff <= nszcx_ff;
      czcx2_ff  <= czcx_ff;
      czsy2_ff  <= czsy_ff;
      szsy2_ff  <= szsy_ff;
      cxcy2_ff  <= cxcy_ff;
      sx2_ff    <= sx1_ff;
   end

   // stage 3
   evp_pkg::evp_mat_type mat_in;
   evp_pkg::evp_mat_type mat_ff;
   logic                 v3_ff;

   always_comb begin
      mat_in.col0_r0 = czcy2_ff - szsxsy_ff;
      mat_in.col0_r1 = szcy2_ff + czsxsy_ff;
      mat_in.col0_r2 = ncxsy2_ff;
      mat_in.col1_r0 = nszcx2_ff;
      mat_in.col1_r1 = czcx2_ff;
      mat_in.col1_r2 = sx2_ff;
      mat_in.col2_r0 = czsy2_ff + szsxcy_ff;
      mat_in.col2_r1 = szsy2_ff - czsxcy_ff;
      mat_in.col2_r2 = cxcy2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      mat_ff <= mat_in;
   end

   assign out_valid = v3_ff;
   assign out_mat   = mat_ff;

endmodule

// ----- hdl/evp_trans.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evp_trans
// Four stage translation column: split partial products, recombine, negated
// row sum, floor and saturate.
// ----------------------------------------------------------------------------
module evp_trans (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  evp_pkg::evp_mat_type               in_mat,
   input  logic signed [evp_pkg::POS_BITS-1:0] pos_x,
   input  logic signed [evp_pkg::POS_BITS-1:0] pos_y,
   input  logic signed [evp_pkg::POS_BITS-1:0] pos_z,
   output logic                               out_valid,
   output evp_pkg::evp_rsp_type               out_rsp
);

   localparam int PB  = evp_pkg::POS_BITS;
   localparam int KW  = evp_pkg::COEF_W;
   localparam int H   = PB / 2;
   localparam int HW  = PB - H;
   localparam int PHW = HW + KW;
   localparam int PLW = H + 1 + KW;
   localparam int PRW = PB + KW;
   localparam int SW  = PRW + 3;

   logic signed [KW-1:0] cf [0:2][0:2];
   logic signed [PB-1:0] pp [0:2];

   always_comb begin
      cf[0][0] = in_mat.col0_r0;
      cf[0][1] = in_mat.col1_r0;
      cf[0][2] = in_mat.col2_r0;
      cf[1][0] = in_mat.col0_r1;
      cf[1][1] = in_mat.col1_r1;
      cf[1][2] = in_mat.col2_r1;
      cf[2][0] = in_mat.col0_r2;
      cf[2][1] = in_mat.col1_r2;
      cf[2][2] = in_mat.col2_r2;
      pp[0]    = pos_x;
      pp[1]    = pos_y;
      pp[2]    = pos_z;
   end

   // stage 1: split products
   logic signed [PHW-1:0] hi_ff [0:2][0:2];
   logic signed [PLW-1:0] lo_ff [0:2][0:2];
   evp_pkg::evp_mat_type  mat1_ff;
   logic                  v1_ff;

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar k = 0; k < 3; k++) begin : g_col
         logic signed [HW-1:0]  ph;
         logic signed [H:0]     pl;
         logic signed [PHW-1:0] hi_in;
         logic signed [PLW-1:0] lo_in;
         assign ph    = pp[k][PB-1:H];
         assign pl    = signed'({1'b0, pp[k][H-1:0]});
         assign hi_in = ph * cf[r][k];
         assign lo_in = pl * cf[r][k];
         always_ff @(posedge clock) begin
            hi_ff[r][k] <= hi_in;
            lo_ff[r][k] <= lo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      mat1_ff <= in_mat;
   end

   // stage 2: recombine
   logic signed [PRW-1:0] prod_ff [0:2][0:2];
   evp_pkg::evp_mat_type  mat2_ff;
   logic                  v2_ff;

   for (genvar r = 0; r < 3; r++) begin : g_row2
      for (genvar k = 0; k < 3; k++) begin : g_col2
         logic signed [PRW-1:0] prod_in;
         assign prod_in = (PRW'(hi_ff[r][k]) <<< H) + PRW'(lo_ff[r][k]);
         always_ff @(posedge clock) begin
            prod_ff[r][k] <= prod_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      mat2_ff <= mat1_ff;
   end

   // stage 3: negated row sums
   logic signed [SW-1:0] sum_ff [0:2];
   evp_pkg::evp_mat_type mat3_ff;
   logic                 v3_ff;

   for (genvar r = 0; r < 3; r++) begin : g_sum
      logic signed [SW-1:0] sum_in;
      assign sum_in = -(SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]) + SW'(prod_ff[r][2]));
      always_ff @(posedge clock) begin
         sum_ff[r] <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      mat3_ff <= mat2_ff;
   end

   // stage 4: floor and saturate
   logic signed [PB-1:0] tr [0:2];

   for (genvar r = 0; r < 3; r++) begin : g_sat
      logic signed [SW-1:0] fl;
      logic                 ovf;
      assign fl    = sum_ff[r] >>> evp_pkg::COEF_FRAC_BITS;
      assign ovf   = (fl[SW-1:PB-1] != {(SW - PB + 1){1'b0}})
                  && (fl[SW-1:PB-1] != {(SW - PB + 1){1'b1}});
      assign tr[r] = ovf ? (fl[SW-1] ? {1'b1, {(PB - 1){1'b0}}} : {1'b0, {(PB - 1){1'b1}}})
                         : fl[PB-1:0];
   end

   evp_pkg::evp_rsp_type rsp_in;
   evp_pkg::evp_rsp_type rsp_ff;
   logic                 v4_ff;

   always_comb begin
      rsp_in.col0_r0 = mat3_ff.col0_r0;
      rsp_in.col0_r1 = mat3_ff.col0_r1;
      rsp_in.col0_r2 = mat3_ff.col0_r2;
      rsp_in.col1_r0 = mat3_ff.col1_r0;
      rsp_in.col1_r1 = mat3_ff.col1_r1;
      rsp_in.col1_r2 = mat3_ff.col1_r2;
      rsp_in.col2_r0 = mat3_ff.col2_r0;
      rsp_in.col2_r1 = mat3_ff.col2_r1;
      rsp_in.col2_r2 = mat3_ff.col2_r2;
      rsp_in.trans_x = tr[0];
      rsp_in.trans_y = tr[1];
      rsp_in.trans_z = tr[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = v4_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ----- hdl/euler_pose_to_view_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_pose_to_view_matrix
// Camera pose (three binary Euler angles and a Q16.16 position) to the nine
// rotation entries and the translation column of the view matrix.
//
// Usage: raise start with a pose on req_data; the pose is taken at any edge
// where start is high, and busy is always low, so a pose may be sent every
// cycle. Each pose yields one result on rsp_data, marked by a one-cycle
// rsp_strobe, in the order the poses were taken.
// Path: sine/cosine (an input register, then one CORDIC rotation per stage,
// 38 stages at 14 coefficient bits, then an output register), the product
// tree and the translation column. Throughput: one pose per cycle.
// Reset clears every valid bit in flight; results in flight are dropped.
// The receiver has no way to hold results off; each result is on the ports
// for its strobe cycle only.
// ----------------------------------------------------------------------------
module euler_pose_to_view_matrix (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  evp_pkg::evp_req_type req_data,
   output logic                 busy,
   output logic                 rsp_strobe,
   output evp_pkg::evp_rsp_type rsp_data
);

   localparam int D = evp_pkg::SINCOS_LATENCY + evp_pkg::MATRIX_LATENCY;

   logic                 vx, vy, vz;
   evp_pkg::evp_sc_type  scx, scy, scz;
   logic                 mat_valid;
   evp_pkg::evp_mat_type mat;
   evp_pkg::evp_req_type req_ff [0:D-1];

   assign busy = 1'b0;

   evp_sincos u_sc_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .angle     (req_data.rot_x),
      .out_valid (vx),
      .out_sc    (scx)
   );

   evp_sincos u_sc_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .angle     (req_data.rot_y),
      .out_valid (vy),
      .out_sc    (scy)
   );

   evp_sincos u_sc_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .angle     (req_data.rot_z),
      .out_valid (vz),
      .out_sc    (scz)
   );

   evp_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vx & vy & vz),
      .sc_x      (scx),
      .sc_y      (scy),
      .sc_z      (scz),
      .out_valid (mat_valid),
      .out_mat   (mat)
   );

   always_ff @(posedge clock) begin
      req_ff[0] <= req_data;
   end

   for (genvar i = 1; i < D; i++) begin : g_dly
      always_ff @(posedge clock) begin
         req_ff[i] <= req_ff[i-1];
      end
   end

   evp_trans u_trans (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .in_mat    (mat),
      .pos_x     (req_ff[D-1].pos_x),
      .pos_y     (req_ff[D-1].pos_y),
      .pos_z     (req_ff[D-1].pos_z),
      .out_valid (rsp_strobe),
      .out_rsp   (rsp_data)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Pose to view matrix check: a directed table of poses (zero angles, quarter
// and half turns, octant edges, position extremes and translation saturation)
// followed by 1100 random poses. Each prediction is a typed view or a local
// bit-exact model of the sine/cosine, product and translation arithmetic;
// each strobed result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import evp_pkg::*;

   localparam int RANDOM_POSES = 1100;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      evp_req_type pose;
      bit          typed;
      evp_rsp_type view;
   } pose_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   evp_req_type req_data = '0;
   logic        busy;
   logic        rsp_strobe;
   evp_rsp_type rsp_data;

   evp_rsp_type  view_queue[$];
   pose_row_type pose_table[$];
   int           mismatch_count = 0;
   bit           busy_free_stretch = 1'b0;

   euler_pose_to_view_matrix i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned mul_frac62(longint unsigned a, longint unsigned b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   function automatic void sine_cosine(input logic [ANGLE_BITS-1:0] ang,
                                       output longint sn, output longint cs);
      longint unsigned r, t, x, x2, s, c, ts, tc;
      longint          sv, cv, tmp;
      int              q;
      bit              swap;
      q    = ang[ANGLE_BITS-1 -: 2];
      r    = ang[ANGLE_BITS-3:0];
      swap = r > (64'd1 << (ANGLE_BITS - 3));
      t    = swap ? (64'd1 << (ANGLE_BITS - 2)) - r : r;
      x    = mul_frac62(t << (64 - ANGLE_BITS), 64'h6487ED5110B4611A);
      x2   = mul_frac62(x, x);
      s    = x;
      c    = 64'd1 << 62;
      ts   = x;
      tc   = 64'd1 << 62;
      for (int n = 1; n <= 12; n++) begin
         ts = mul_frac62(ts, x2) / longint'((2 * n) * (2 * n + 1));
         tc = mul_frac62(tc, x2) / longint'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            s -= ts;
            c -= tc;
         end else begin
            s += ts;
            c += tc;
         end
      end
      sv = longint'((s + (64'd1 << (61 - COEF_FRAC_BITS))) >> (62 - COEF_FRAC_BITS));
      cv = longint'((c + (64'd1 << (61 - COEF_FRAC_BITS))) >> (62 - COEF_FRAC_BITS));
      if (swap) begin
         tmp = sv;
         sv  = cv;
         cv  = tmp;
      end
      case (q)
         0: begin sn = sv;  cs = cv;  end
         1: begin sn = cv;  cs = -sv; end
         2: begin sn = -sv; cs = -cv; end
         default: begin sn = -cv; cs = sv; end
      endcase
   endfunction

   function automatic longint coef_mul(longint a, longint b);
      return (a * b) >>> COEF_FRAC_BITS;
   endfunction

   function automatic logic [POS_BITS-1:0] view_offset(longint px, longint py, longint pz,
                                                       longint a, longint b, longint c);
      longint acc;
      longint hi_lim, lo_lim;
      hi_lim = (longint'(1) <<< (POS_BITS - 1)) - 1;
      lo_lim = -hi_lim - 1;
      acc    = -(px * a + py * b + pz * c);
      acc    = acc >>> COEF_FRAC_BITS;
      if (acc > hi_lim) acc = hi_lim;
      if (acc < lo_lim) acc = lo_lim;
      return acc[POS_BITS-1:0];
   endfunction

   function automatic evp_rsp_type pose_to_view(evp_req_type p);
      longint      sx, cx, sy, cy, sz, cz, px, py, pz;
      longint      m[9];
      evp_rsp_type v;
      sine_cosine(p.rot_x, sx, cx);
      sine_cosine(p.rot_y, sy, cy);
      sine_cosine(p.rot_z, sz, cz);
      px   = p.pos_x;
      py   = p.pos_y;
      pz   = p.pos_z;
      m[0] = coef_mul(cz, cy) - coef_mul(coef_mul(sz, sx), sy);
      m[1] = coef_mul(sz, cy) + coef_mul(coef_mul(cz, sx), sy);
      m[2] = (-(cx * sy)) >>> COEF_FRAC_BITS;
      m[3] = (-(sz * cx)) >>> COEF_FRAC_BITS;
      m[4] = coef_mul(cz, cx);
      m[5] = sx;
      m[6] = coef_mul(cz, sy) + coef_mul(coef_mul(sz, sx), cy);
      m[7] = coef_mul(sz, sy) - coef_mul(coef_mul(cz, sx), cy);
      m[8] = coef_mul(cx, cy);
      v.col0_r0 = m[0][COEF_W-1:0];
      v.col0_r1 = m[1][COEF_W-1:0];
      v.col0_r2 = m[2][COEF_W-1:0];
      v.col1_r0 = m[3][COEF_W-1:0];
      v.col1_r1 = m[4][COEF_W-1:0];
      v.col1_r2 = m[5][COEF_W-1:0];
      v.col2_r0 = m[6][COEF_W-1:0];
      v.col2_r1 = m[7][COEF_W-1:0];
      v.col2_r2 = m[8][COEF_W-1:0];
      v.trans_x = view_offset(px, py, pz, m[0], m[3], m[6]);
      v.trans_y = view_offset(px, py, pz, m[1], m[4], m[7]);
      v.trans_z = view_offset(px, py, pz, m[2], m[5], m[8]);
      return v;
   endfunction

   function automatic evp_rsp_type identity_view(logic [POS_BITS-1:0] tx,
                                                 logic [POS_BITS-1:0] ty,
                                                 logic [POS_BITS-1:0] tz);
      evp_rsp_type v;
      v = '0;
      v.col0_r0 = 16'sd16384;
      v.col1_r1 = 16'sd16384;
      v.col2_r2 = 16'sd16384;
      v.trans_x = tx;
      v.trans_y = ty;
      v.trans_z = tz;
      return v;
   endfunction

   function automatic evp_req_type make_pose(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                             logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pz);
      evp_req_type p;
      p.rot_x = ax;
      p.rot_y = ay;
      p.rot_z = az;
      p.pos_x = px;
      p.pos_y = py;
      p.pos_z = pz;
      return p;
   endfunction

   function automatic logic [15:0] pick_angle();
      logic [15:0] edges[10] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000,
                                 16'h2001, 16'h1FFF, 16'hFFFF, 16'h7FFF, 16'h6000};
      if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 9)];
      return 16'($urandom);
   endfunction

   function automatic logic [31:0] pick_position();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_row(evp_req_type p, bit typed, evp_rsp_type v);
      pose_row_type row;
      row.pose  = p;
      row.typed = typed;
      row.view  = v;
      pose_table.insert(pose_table.size(), row);
   endfunction

   task automatic send_pose(evp_req_type p);
      if (!busy_free_stretch) begin
         while ($urandom_range(0, 99) < 36) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         if (pose_table.size() > 0 && pose_table[0].pose == req_data) begin
            view_queue.insert(view_queue.size(),
                              pose_table[0].typed ? pose_table[0].view
                                                  : pose_to_view(req_data));
            void'(pose_table.pop_front());
         end else begin
            view_queue.insert(view_queue.size(), pose_to_view(req_data));
         end
      end
   end

   always @(posedge clock) begin
      evp_rsp_type expected;
      logic [31:0] exp_f[12];
      logic [31:0] act_f[12];
      string       names[12] = '{"col0_r0", "col0_r1", "col0_r2", "col1_r0", "col1_r1",
                                 "col1_r2", "col2_r0", "col2_r1", "col2_r2", "trans_x",
                                 "trans_y", "trans_z"};
      if (!reset && rsp_strobe) begin
         if (view_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            expected = view_queue.pop_front();
            exp_f = '{expected.col0_r0, expected.col0_r1, expected.col0_r2,
                      expected.col1_r0, expected.col1_r1, expected.col1_r2,
                      expected.col2_r0, expected.col2_r1, expected.col2_r2,
                      expected.trans_x, expected.trans_y, expected.trans_z};
            act_f = '{rsp_data.col0_r0, rsp_data.col0_r1, rsp_data.col0_r2,
                      rsp_data.col1_r0, rsp_data.col1_r1, rsp_data.col1_r2,
                      rsp_data.col2_r0, rsp_data.col2_r1, rsp_data.col2_r2,
                      rsp_data.trans_x, rsp_data.trans_y, rsp_data.trans_z};
            for (int k = 0; k < 12; k++) begin
               if (act_f[k] !== exp_f[k]) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%s: expected %h, got %h", names[k], exp_f[k], act_f[k]);
               end
            end
         end
      end
   end

   initial begin
      evp_rsp_type dummy;
      int          waited;
      int          rows;
      dummy = '0;
      add_row(make_pose(0, 0, 0, 0, 0, 0), 1'b1, identity_view(0, 0, 0));
      add_row(make_pose(0, 0, 0, 32'h00010000, 32'hFFFE0000, 32'h00000003), 1'b1,
              identity_view(32'hFFFF0000, 32'h00020000, 32'hFFFFFFFD));
      add_row(make_pose(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000), 1'b1,
              identity_view(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
      add_row(make_pose(0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b1,
              identity_view(32'h80000001, 32'h80000001, 32'h80000001));
      add_row(make_pose(16'h4000, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF), 0, dummy);
      add_row(make_pose(0, 16'h4000, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000), 0, dummy);
      add_row(make_pose(0, 0, 16'h4000, 32'h00010000, 32'h00020000, 32'h00030000), 0, dummy);
      add_row(make_pose(16'h8000, 16'h8000, 16'h8000, 32'h80000000, 0, 32'h7FFFFFFF), 0, dummy);
      add_row(make_pose(16'hC000, 16'hC000, 16'hC000, 32'h12345678, 32'h9ABCDEF0, 0), 0, dummy);
      add_row(make_pose(16'h7FFF, 16'hFFFF, 16'h8001, 32'hFFFFFFFF, 1, 32'h80000001), 0, dummy);
      add_row(make_pose(16'h2000, 16'h2000, 16'h2000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h7FFFFFFF), 0, dummy);
      add_row(make_pose(16'h2001, 16'h1FFF, 16'h6000, 32'h80000000, 32'h80000000,
                        32'h80000000), 0, dummy);
      add_row(make_pose(16'hA000, 16'hE000, 16'h5FFF, 32'h00008000, 32'hFFFF8000,
                        32'h00000001), 0, dummy);
      add_row(make_pose(16'h0001, 16'hFFFF, 16'h3FFF, 32'h55555555, 32'hAAAAAAAA,
                        32'h0F0F0F0F), 0, dummy);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      rows = pose_table.size();
      for (int i = 0; i < rows; i++) send_pose(pose_table[0].pose);
      for (int i = 0; i < RANDOM_POSES; i++) begin
         busy_free_stretch = (i >= 400 && i < 600);
         send_pose(make_pose(pick_angle(), pick_angle(), pick_angle(),
                             pick_position(), pick_position(), pick_position()));
      end
      start <= 1'b0;

      waited = 0;
      while (view_queue.size() > 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && view_queue.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_top: errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/evp_pkg.sv
hdl/evp_sincos.sv
hdl/evp_matrix.sv
hdl/evp_trans.sv
hdl/euler_pose_to_view_matrix.sv
tb/tb_top.sv
